// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define W2S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that implies another in the same cycle.
`define W2S_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/w2s_pkg.sv =====
// ---------------------------------------------------------------------------
// World-to-screen projection package
// Widths, codes, reset values and word types shared by the projection core.
// ---------------------------------------------------------------------------
package w2s_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MATRIX_ENTRIES = 16;
  localparam int MAT_DIM        = 4;
  localparam int ENTRY_W        = $clog2(MATRIX_ENTRIES);
  localparam int ROW_IDX_W      = $clog2(MAT_DIM);
  localparam int COORDS         = 3;
  localparam int LANES          = 3;
  localparam int LANE_X         = 0;
  localparam int LANE_Y         = 1;
  localparam int LANE_W         = 2;

  localparam int COORD_W = 32;
  localparam int DIGIT_W = 8;
  localparam int DIGITS  = COORD_W / DIGIT_W;
  localparam int HI_W    = COORD_W + DIGIT_W + 1;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SH_W    = PROD_W - FRAC_BITS;
  localparam int ACC_W   = SH_W + 2;
  localparam int QUO_W   = COORD_W - 1;
  localparam int NUM_SH  = QUO_W - FRAC_BITS;
  localparam int VIEW_W  = 16;
  localparam int NEAR_W  = 31;
  localparam int SUM_W   = COORD_W + 1;
  localparam int MAP_W   = VIEW_W + 1 + SUM_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NEAR_W;

  localparam logic [ROW_IDX_W-1:0] ROW_CX = ROW_IDX_W'(0);
  localparam logic [ROW_IDX_W-1:0] ROW_CY = ROW_IDX_W'(1);
  localparam logic [ROW_IDX_W-1:0] ROW_CW = ROW_IDX_W'(3);

  localparam logic [VIEW_W-1:0] VIEW_W_RST = VIEW_W'(640);
  localparam logic [VIEW_W-1:0] VIEW_H_RST = VIEW_W'(480);
  localparam logic [NEAR_W-1:0] NEAR_RST   = NEAR_W'(6554);

  localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]   NDC_ONE = SUM_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_WIDTH  = 2'd0,
    CFG_VIEW_HEIGHT = 2'd1,
    CFG_NEAR_LIMIT  = 2'd2
  } w2s_cfg_e;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_PROJECT = 1'b1
  } w2s_op_e;

  typedef struct packed {
    w2s_op_e                     op;
    logic [ENTRY_W-1:0]          entry_index;
    logic signed [COORD_W-1:0]   entry_value;
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic signed [COORD_W-1:0]   point_z;
  } w2s_in_t;

  typedef struct packed {
    logic                        visible;
    logic signed [COORD_W-1:0]   screen_x;
    logic signed [COORD_W-1:0]   screen_y;
  } w2s_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic accum;
  } w2s_mac_ctrl_t;

endpackage

// ===== src/w2s_mac_lane.sv =====
// ---------------------------------------------------------------------------
// Byte-serial multiply-accumulate lane
// Forms one clip row as the sum of three floored coordinate products and a
// translation term, taking one byte of the coordinate per cycle.
// ---------------------------------------------------------------------------
module w2s_mac_lane (
  input  logic                                 clk_i,
  input  w2s_pkg::w2s_mac_ctrl_t               ctrl_i,
  input  logic signed [w2s_pkg::COORD_W-1:0]   coef_i,
  input  logic signed [w2s_pkg::DIGIT_W:0]     digit_i,
  input  logic signed [w2s_pkg::COORD_W-1:0]   bias_i,
  output logic signed [w2s_pkg::ACC_W-1:0]     acc_o
);
  import w2s_pkg::*;

  logic signed [HI_W-1:0]    hi_q, hi_d;
  logic [COORD_W-1:0]        lo_q, lo_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [HI_W-1:0]    pp;
  logic signed [HI_W:0]      sum_t;
  logic signed [HI_W:0]      sum_sh;
  logic [PROD_W-1:0]         prod;
  logic signed [SH_W-1:0]    prod_sh;

  always_comb begin
    pp      = coef_i * digit_i;
    sum_t   = {hi_q[HI_W-1], hi_q} + {pp[HI_W-1], pp};
    sum_sh  = sum_t >>> DIGIT_W;
    prod    = {hi_q[COORD_W-1:0], lo_q};
    prod_sh = prod[PROD_W-1:FRAC_BITS];
    hi_d    = hi_q;
    lo_d    = lo_q;
    acc_d   = acc_q;
    if (ctrl_i.load) begin
      hi_d  = '0;
      lo_d  = '0;
      acc_d = {{(ACC_W-COORD_W){bias_i[COORD_W-1]}}, bias_i};
    end else if (ctrl_i.step) begin
      hi_d = sum_sh[HI_W-1:0];
      lo_d = {sum_t[DIGIT_W-1:0], lo_q[COORD_W-1:DIGIT_W]};
    end else if (ctrl_i.accum) begin
      hi_d  = '0;
      lo_d  = '0;
      acc_d = acc_q + {{(ACC_W-SH_W){prod_sh[SH_W-1]}}, prod_sh};
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== src/w2s_divider.sv =====
// ---------------------------------------------------------------------------
// Bit-serial fixed-point divider
// Divides a signed clip coordinate by a positive clip w, one quotient bit
// per cycle, truncated toward zero and saturated to 32 bits.
// ---------------------------------------------------------------------------
module w2s_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [w2s_pkg::ACC_W-1:0]     num_i,
  input  logic [w2s_pkg::ACC_W-1:0]            den_i,
  output logic                                 done_o,
  output logic signed [w2s_pkg::COORD_W-1:0]   quot_o
);
  import w2s_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  typedef enum logic [3:0] {
    DV_IDLE  = 4'b0001,
    DV_SETUP = 4'b0010,
    DV_ITER  = 4'b0100,
    DV_DONE  = 4'b1000
  } div_state_e;

  div_state_e         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q;
  logic               sat_q;
  logic [ACC_W-1:0]   mag_q;
  logic [ACC_W-1:0]   den_q;
  logic [ACC_W-1:0]   rem_q;
  logic [QUO_W-1:0]   low_q;
  logic [QUO_W-1:0]   quo_q;
  logic [ACC_W-1:0]   mag_sh;
  logic [ACC_W:0]     rem2;
  logic [ACC_W:0]     diff;
  logic               fit;

  always_comb begin
    mag_sh = mag_q >> NUM_SH;
    rem2   = {rem_q, low_q[QUO_W-1]};
    diff   = rem2 - {1'b0, den_q};
    fit    = !diff[ACC_W];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          state_d = DV_SETUP;
        end
      end
      DV_SETUP: begin
        state_d = DV_ITER;
        cnt_d   = CNT_W'(QUO_W - 1);
      end
      DV_ITER: begin
        if (cnt_q == '0) begin
          state_d = DV_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      DV_DONE: begin
        state_d = DV_IDLE;
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && start_i) begin
      neg_q <= num_i[ACC_W-1];
      mag_q <= num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
      den_q <= den_i;
    end
    if (state_q == DV_SETUP) begin
      sat_q <= mag_sh >= den_q;
      rem_q <= mag_sh;
      low_q <= {mag_q[NUM_SH-1:0], {FRAC_BITS{1'b0}}};
    end
    if (state_q == DV_ITER) begin
      low_q <= low_q << 1;
      rem_q <= fit ? diff[ACC_W-1:0] : rem2[ACC_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fit};
    end
  end

  always_comb begin
    if (sat_q) begin
      quot_o = neg_q ? SAT_MIN : SAT_MAX;
    end else if (neg_q) begin
      quot_o = -$signed({1'b0, quo_q});
    end else begin
      quot_o = $signed({1'b0, quo_q});
    end
  end

  assign done_o = (state_q == DV_DONE);

endmodule

// ===== src/world_to_screen_projection_core.sv =====
// ---------------------------------------------------------------------------
// World-to-screen projection core
// Projects world points through a stored 4x4 column-major Q16.16 matrix and
// maps them to window coordinates, flagging points behind the near limit.
//
//   Channel   Direction   Handshake              Word
//   cfg       in          cfg_valid/cfg_ready    cfg_index_i, cfg_data_i
//   in        in          in_valid/in_stall      w2s_in_t
//   out       out         out_valid/out_stall    w2s_out_t
//
// Words are taken only while the core is idle, so no new word is taken until
// a point is finished. Three byte-serial row lanes run first; a visible point
// then goes to the two bit-serial dividers, which produce one quotient bit per
// cycle, while a point short of the near limit skips them.
// Reset restores the viewport and near limit; matrix entries hold nothing
// until written. A finished result waits in the output register, and a new
// word is accepted meanwhile; the core holds at the end of the next point
// until that result is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module world_to_screen_projection_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [w2s_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [w2s_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  w2s_pkg::w2s_in_t                     in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output w2s_pkg::w2s_out_t                    out_word_o
);
  import w2s_pkg::*;

  localparam int STEP_W = $clog2(DIGITS + 1);
  localparam int COL_W  = $clog2(MAT_DIM);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MAC   = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_MAP   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  function automatic logic signed [COORD_W-1:0] sat_half(
    input logic signed [MAP_W-1:0] p
  );
    logic [MAP_W-COORD_W-1:0] top_bits;
    top_bits = p[MAP_W-1:COORD_W];
    if (top_bits == '0 || top_bits == '1) begin
      return p[COORD_W:1];
    end else if (p[MAP_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  state_e                    state_q, state_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_load;
  logic                      div_start;
  logic                      in_acc;
  logic                      vis_now;
  w2s_mac_ctrl_t             mac_ctrl;

  logic [VIEW_W-1:0]         view_w_q;
  logic [VIEW_W-1:0]         view_h_q;
  logic [NEAR_W-1:0]         near_q;
  logic [NEAR_W-1:0]         near_eff;

  logic signed [COORD_W-1:0] mat_q [LANES][MAT_DIM];
  logic signed [COORD_W-1:0] digit_q;
  logic signed [COORD_W-1:0] py_q;
  logic signed [COORD_W-1:0] pz_q;
  logic signed [DIGIT_W:0]   digit_s;
  logic signed [ACC_W-1:0]   clip [LANES];
  logic signed [ACC_W-1:0]   clip_w;
  logic                      vis_q;
  logic                      div_x_done;
  logic                      div_y_done;
  logic signed [COORD_W-1:0] quot_x;
  logic signed [COORD_W-1:0] quot_y;
  logic signed [COORD_W-1:0] nx_q;
  logic signed [COORD_W-1:0] ny_q;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic signed [MAP_W-1:0]   prod_x_q;
  logic signed [MAP_W-1:0]   prod_y_q;
  w2s_out_t                  out_word_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_w_q <= VIEW_W_RST;
      view_h_q <= VIEW_H_RST;
      near_q   <= NEAR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (w2s_cfg_e'(cfg_index_i))
        CFG_VIEW_WIDTH:  view_w_q <= cfg_data_i[VIEW_W-1:0];
        CFG_VIEW_HEIGHT: view_h_q <= cfg_data_i[VIEW_W-1:0];
        CFG_NEAR_LIMIT:  near_q   <= cfg_data_i[NEAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    digit_s = (step_q == STEP_W'(DIGITS - 1)) ?
              {digit_q[DIGIT_W-1], digit_q[DIGIT_W-1:0]} :
              {1'b0, digit_q[DIGIT_W-1:0]};
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    w2s_mac_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (mac_ctrl),
      .coef_i  (mat_q[l][col_q]),
      .digit_i (digit_s),
      .bias_i  (mat_q[l][MAT_DIM-1]),
      .acc_o   (clip[l])
    );
  end

  assign clip_w   = clip[LANE_W];
  assign near_eff = (near_q == '0) ? NEAR_W'(1) : near_q;
  assign vis_now  = clip_w >= $signed({{(ACC_W-NEAR_W){1'b0}}, near_eff});

  w2s_divider u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (clip[LANE_X]),
    .den_i   ($unsigned(clip_w)),
    .done_o  (div_x_done),
    .quot_o  (quot_x)
  );

  w2s_divider u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (clip[LANE_Y]),
    .den_i   ($unsigned(clip_w)),
    .done_o  (div_y_done),
    .quot_o  (quot_y)
  );

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    col_d     = col_q;
    mac_ctrl  = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_word_i.op == OP_PROJECT) begin
          state_d       = ST_MAC;
          step_d        = '0;
          col_d         = '0;
          mac_ctrl.load = 1'b1;
        end
      end
      ST_MAC: begin
        if (step_q != STEP_W'(DIGITS)) begin
          mac_ctrl.step = 1'b1;
          step_d        = step_q + 1'b1;
        end else begin
          mac_ctrl.accum = 1'b1;
          step_d         = '0;
          if (col_q == COL_W'(COORDS - 1)) begin
            state_d = ST_CHECK;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (vis_now) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_x_done) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    sum_x = {nx_q[COORD_W-1], nx_q} + NDC_ONE;
    sum_y = NDC_ONE - {ny_q[COORD_W-1], ny_q};
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.op == OP_WRITE) begin
      case (in_word_i.entry_index[ROW_IDX_W-1:0])
        ROW_CX: mat_q[LANE_X][in_word_i.entry_index[ENTRY_W-1:ROW_IDX_W]] <=
                  in_word_i.entry_value;
        ROW_CY: mat_q[LANE_Y][in_word_i.entry_index[ENTRY_W-1:ROW_IDX_W]] <=
                  in_word_i.entry_value;
        ROW_CW: mat_q[LANE_W][in_word_i.entry_index[ENTRY_W-1:ROW_IDX_W]] <=
                  in_word_i.entry_value;
        default: begin
        end
      endcase
    end
    if (mac_ctrl.load) begin
      digit_q <= in_word_i.point_x;
      py_q    <= in_word_i.point_y;
      pz_q    <= in_word_i.point_z;
    end else if (mac_ctrl.step) begin
      digit_q <= digit_q >> DIGIT_W;
    end else if (mac_ctrl.accum) begin
      digit_q <= (col_q == '0) ? py_q : pz_q;
    end
    if (state_q == ST_CHECK) begin
      vis_q <= vis_now;
    end
    if (state_q == ST_DIV && div_x_done) begin
      nx_q <= quot_x;
      ny_q <= quot_y;
    end
    if (state_q == ST_MAP) begin
      prod_x_q <= $signed({1'b0, view_w_q}) * sum_x;
      prod_y_q <= $signed({1'b0, view_h_q}) * sum_y;
    end
    if (out_load) begin
      out_word_q.visible  <= vis_q;
      out_word_q.screen_x <= vis_q ? sat_half(prod_x_q) : '0;
      out_word_q.screen_y <= vis_q ? sat_half(prod_y_q) : '0;
    end
  end

  `W2S_ASSERT(a_div_lockstep, div_x_done == div_y_done, "Divider lanes lost lockstep.")
  `W2S_ASSERT_IMPLY(a_div_positive_w, state_q == ST_DIV, clip_w > 0, "Division by nonpositive w.")
  `W2S_ASSERT_IMPLY(a_hidden_zero, out_valid_o && !out_word_o.visible, out_word_o.screen_x == '0 && out_word_o.screen_y == '0, "Hidden point with nonzero coordinates.")
  `W2S_ASSERT(a_mac_ctrl_single, $onehot0(mac_ctrl), "Lane controls overlap.")

endmodule
